/* rtl/core/p16ln_pkg.sv */
// Shared types and constants for the posit16 natural log pipeline.
// Depends on nothing; every other file in rtl/core imports it.
package p16ln_pkg;

  // Cycles from an accepted request to its result strobe.
  localparam int unsigned LATENCY = 22;

  localparam logic [15:0] POSIT_NAR = 16'h8000;

  // Restoring divider for z = f / (f + 2^13): quotient bits per stage and stage count.
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = 8;

  // Odd polynomial coefficients of the log2 mantissa.
  localparam logic [10:0] POLY_C1 = 11'd1584;
  localparam logic [14:0] POLY_C2 = 15'd26661;
  localparam logic [18:0] POLY_C3 = 19'd302676;
  localparam logic [23:0] POLY_C4 = 24'd16136153;
  localparam logic [27:0] POLY_C5 = 28'd193635259;

  // ln2 factors in Q28, one per sign of the log2 value.
  localparam logic [27:0] LN2_POS_K = 28'd186065279;
  localparam logic [27:0] LN2_NEG_K = 28'd186065280;

  // Control that travels with every request.
  typedef struct packed {
    logic              valid;
    logic              nar;
    logic signed [5:0] scale;
  } tag_t;

endpackage

/* rtl/core/p16ln_div.sv */
// Pipelined restoring divider: z = ((f << 31) + 2) / (f + 8192), four quotient bits per stage.
// Depends on p16ln_pkg.
module p16ln_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  p16ln_pkg::tag_t   tag_i,
  input  logic [11:0]       frac_i,
  output p16ln_pkg::tag_t   tag_o,
  output logic [29:0]       z_o
);
  import p16ln_pkg::*;

  tag_t        tag_q [DIV_STAGES];
  logic [13:0] rem_q [DIV_STAGES];
  logic [13:0] den_q [DIV_STAGES];
  logic [31:0] quo_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    tag_t                  tag_in;
    logic [13:0]           rem_in;
    logic [13:0]           den_in;
    logic [31:0]           quo_in;
    logic [DIV_BITS-1:0]   nbits;
    logic [13:0]           rem_d;
    logic [DIV_BITS-1:0]   qbits;

    if (j == 0) begin : g_first
      // numerator bit 31 is f[0]; the bits above it seed the remainder
      assign tag_in = tag_i;
      assign rem_in = {3'b000, frac_i[11:1]};
      assign den_in = {2'b10, frac_i};
      assign quo_in = '0;
      assign nbits  = {frac_i[0], 3'b000};
    end else begin : g_next
      assign tag_in = tag_q[j-1];
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
      // the "+2" of the numerator lands in bit 1
      assign nbits  = (j == DIV_STAGES - 1) ? 4'b0010 : 4'b0000;
    end

    always_comb begin
      logic [14:0] trial;
      logic [13:0] r;
      r     = rem_in;
      qbits = '0;
      for (int b = DIV_BITS - 1; b >= 0; b--) begin
        trial = {r, nbits[b]};
        if (trial >= {1'b0, den_in}) begin
          trial    = trial - {1'b0, den_in};
          qbits[b] = 1'b1;
        end
        r = trial[13:0];
      end
      rem_d = r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[j] <= '0;
      end else begin
        tag_q[j] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j] <= rem_d;
      den_q[j] <= den_in;
      quo_q[j] <= {quo_in[31-DIV_BITS:0], qbits};
    end
  end

  assign tag_o = tag_q[DIV_STAGES-1];
  assign z_o   = quo_q[DIV_STAGES-1][29:0];

endmodule

/* rtl/core/p16ln_poly.sv */
// Six-stage Horner evaluation of the log2 mantissa from z, one multiplier per stage.
// Depends on p16ln_pkg.
module p16ln_poly (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  p16ln_pkg::tag_t   tag_i,
  input  logic [29:0]       z_i,
  output p16ln_pkg::tag_t   tag_o,
  output logic [30:0]       mant_o
);
  import p16ln_pkg::*;

  tag_t        tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, tag6_q;
  logic [29:0] z1_q, z2_q, z3_q, z4_q, z5_q;
  logic [28:0] zz1_q, zz2_q, zz3_q, zz4_q;
  logic [11:0] a1_q;
  logic [14:0] a2_q;
  logic [20:0] a3_q;
  logic [23:0] a4_q;
  logic [30:0] mant_q;

  logic [59:0] p1;
  logic [39:0] p2;
  logic [43:0] p3;
  logic [47:0] p4;
  logic [53:0] p5;
  logic [57:0] p6;
  logic [14:0] c2;
  logic [18:0] c3;
  logic [24:0] c4;
  logic [27:0] c5;

  assign p1 = z_i * z_i;
  assign p2 = zz1_q * POLY_C1;
  assign c2 = POLY_C2 + {3'b000, a1_q};
  assign p3 = zz2_q * c2;
  assign c3 = POLY_C3 + {4'b0000, a2_q};
  assign p4 = zz3_q * c3;
  assign c4 = {1'b0, POLY_C4} + {4'b0000, a3_q};
  assign p5 = zz4_q * c4;
  assign c5 = POLY_C5 + {4'b0000, a4_q};
  assign p6 = z5_q * c5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
      tag5_q <= '0;
      tag6_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      tag5_q <= tag4_q;
      tag6_q <= tag5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    z1_q   <= z_i;
    zz1_q  <= p1[58:30];
    z2_q   <= z1_q;
    zz2_q  <= zz1_q;
    a1_q   <= p2[39:28];
    z3_q   <= z2_q;
    zz3_q  <= zz2_q;
    a2_q   <= p3[43:29];
    z4_q   <= z3_q;
    zz4_q  <= zz3_q;
    a3_q   <= p4[47:27];
    z5_q   <= z4_q;
    a4_q   <= p5[53:30];
    mant_q <= p6[57:27];
  end

  assign tag_o  = tag6_q;
  assign mant_o = mant_q;

endmodule

/* rtl/core/p16ln_enc.sv */
// ln2 scaling of the fixed-point log2 and posit16 encoding with round-to-nearest-even.
// Depends on p16ln_pkg.
module p16ln_enc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  p16ln_pkg::tag_t   tag_i,
  input  logic [30:0]       mant_i,
  output logic              valid_o,
  output logic [15:0]       posit_o
);
  import p16ln_pkg::*;

  function automatic logic [4:0] lzc30(input logic [29:0] v);
    logic [4:0] n;
    logic       run;
    n   = '0;
    run = 1'b1;
    for (int i = 29; i >= 0; i--) begin
      if (run && !v[i]) n = n + 5'd1;
      if (v[i]) run = 1'b0;
    end
    return n;
  endfunction

  // L1: join scale and mantissa, take the magnitude
  tag_t        t1_q;
  logic [35:0] m1_q;
  logic [35:0] acc;
  assign acc = {tag_i.scale, 30'b0} | {5'b00000, mant_i};

  // L2: two partial products
  tag_t        t2_q;
  logic        s2_q;
  logic [45:0] pl2_q, ph2_q;
  logic [27:0] kmul;
  logic [45:0] pl_d, ph_d;
  assign kmul = t1_q.scale[5] ? LN2_NEG_K : LN2_POS_K;
  assign pl_d = m1_q[17:0] * kmul;
  assign ph_d = m1_q[35:18] * kmul;

  // L3: sum, shift, restore sign
  tag_t        t3_q;
  logic [35:0] r3_q;
  logic [63:0] psum;
  logic [35:0] tval;
  assign psum = {ph2_q, 18'b0} + {18'b0, pl2_q};
  assign tval = psum[63:28];

  // L4: sign and magnitude of ln
  tag_t        t4_q;
  logic        n4_q;
  logic [35:0] mag4_q;

  // E1: classify and count
  tag_t        t5_q;
  logic        n5_q, z5_q, sm5_q;
  logic [35:0] mag5_q;
  logic [4:0]  lz5_q;
  logic [2:0]  sh5_q;
  logic [2:0]  sh_d;

  always_comb begin
    if (mag4_q[35])      sh_d = 3'd5;
    else if (mag4_q[34]) sh_d = 3'd4;
    else if (mag4_q[33]) sh_d = 3'd3;
    else if (mag4_q[32]) sh_d = 3'd2;
    else if (mag4_q[31]) sh_d = 3'd1;
    else                 sh_d = 3'd0;
  end

  // E2: build the unrounded posit word and its cut position
  tag_t        t6_q;
  logic        n6_q, z6_q;
  logic [35:0] w6_q;
  logic [5:0]  p6_q;
  logic [35:0] w_d;
  logic [5:0]  p_d;

  always_comb begin
    logic [29:0] vn;
    logic [35:0] vj;
    logic        sticky;
    logic [3:0]  top;
    vn     = mag5_q[29:0] << lz5_q;
    vj     = mag5_q >> sh5_q;
    sticky = |(mag5_q & ~({36{1'b1}} << sh5_q));
    case (sh5_q[2:1])
      2'd0:    top = 4'b0001;
      2'd1:    top = 4'b0011;
      default: top = 4'b0111;
    endcase
    if (sm5_q) begin
      w_d = {5'b00000, 1'b1, ~lz5_q[0], vn[28:0]};
      p_d = 6'd17 + {2'b00, lz5_q[4:1]};
    end else begin
      w_d = {top, 1'b0, sh5_q[0], vj[29:1], vj[0] | sticky};
      p_d = 6'd18 + {4'b0000, sh5_q[2:1]};
    end
  end

  // E3: round to nearest even, cut, apply sign
  logic        v7_q;
  logic [15:0] o7_q;
  logic [15:0] o_d;

  always_comb begin
    logic [35:0] half;
    logic [35:0] wr;
    logic [15:0] res;
    logic        up;
    half = 36'd1 << (p6_q - 6'd1);
    up   = w6_q[p6_q - 6'd1] && ((|(w6_q & (half - 36'd1))) || w6_q[p6_q]);
    wr   = up ? (w6_q + half) : w6_q;
    res  = 16'(wr >> p6_q);
    if (t6_q.nar)  o_d = POSIT_NAR;
    else if (z6_q) o_d = 16'h0000;
    else if (n6_q) o_d = 16'h0000 - res;
    else           o_d = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= '0;
      t5_q <= '0;
      t6_q <= '0;
      v7_q <= 1'b0;
    end else begin
      t1_q <= tag_i;
      t2_q <= t1_q;
      t3_q <= t2_q;
      t4_q <= t3_q;
      t5_q <= t4_q;
      t6_q <= t5_q;
      v7_q <= t6_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q   <= tag_i.scale[5] ? (36'd0 - acc) : acc;
    s2_q   <= t1_q.scale[5];
    pl2_q  <= pl_d;
    ph2_q  <= ph_d;
    r3_q   <= s2_q ? (36'd0 - tval) : tval;
    n4_q   <= r3_q[35];
    mag4_q <= r3_q[35] ? (36'd0 - r3_q) : r3_q;
    n5_q   <= n4_q;
    z5_q   <= (mag4_q == 36'd0);
    sm5_q  <= (mag4_q[35:30] == 6'd0);
    mag5_q <= mag4_q;
    lz5_q  <= lzc30(mag4_q[29:0]);
    sh5_q  <= sh_d;
    n6_q   <= n5_q;
    z6_q   <= z5_q;
    w6_q   <= w_d;
    p6_q   <= p_d;
    o7_q   <= o_d;
  end

  assign valid_o = v7_q;
  assign posit_o = o7_q;

endmodule

/* rtl/core/posit16_natural_log_top.sv */
// Top level of the posit16 (es=1) natural logarithm pipeline.
// Depends on p16ln_pkg, p16ln_div, p16ln_poly and p16ln_enc.
//
//  channel   | ports                     | direction | handshake
//  ----------+---------------------------+-----------+----------------------------------
//  request   | start, busy, posit_in_i   | in        | taken when start && !busy
//  result    | done_o, posit_out_o       | out       | one-cycle strobe, never held off
//
// A request may enter every cycle; p16ln_pkg::LATENCY holds the delay to its result strobe.
// The depth is set by the 8-stage restoring divider, the 6 polynomial multiplier stages,
// the decode register and 7 stages of ln2 scaling and posit encoding.
// busy stays low: nothing downstream can stall, so the pipeline never holds.
// Reset clears every valid bit; payload registers keep whatever they hold.
module posit16_natural_log_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] posit_in_i,
  output logic        done_o,
  output logic [15:0] posit_out_o
);
  import p16ln_pkg::*;

  // Count the regime run below the sign-adjacent bit.
  function automatic logic [3:0] lead_run(input logic [13:0] v, input logic bitval);
    logic [3:0] n;
    logic       run;
    n   = '0;
    run = 1'b1;
    for (int i = 13; i >= 0; i--) begin
      if (run && (v[i] == bitval)) n = n + 4'd1;
      if (v[i] != bitval) run = 1'b0;
    end
    return n;
  endfunction

  logic        accept;
  logic [3:0]  run_len;
  logic [13:0] body;
  logic [5:0]  run2;
  tag_t        tag_d, dec_tag_q;
  logic [11:0] dec_frac_q;
  tag_t        div_tag, poly_tag;
  logic [29:0] div_z;
  logic [30:0] poly_mant;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode: the regime run gives twice the regime value, the bit after its terminator adds the exponent.
  assign run_len = lead_run(posit_in_i[13:0], posit_in_i[14]);
  assign body    = posit_in_i[13:0] << run_len;
  assign run2    = {1'b0, run_len, 1'b0};

  always_comb begin
    tag_d.valid = accept;
    tag_d.nar   = (posit_in_i == 16'h0000) || posit_in_i[15];
    if (posit_in_i[14]) tag_d.scale = run2 + {5'b00000, body[12]};
    else                tag_d.scale = 6'd0 - 6'd2 - run2 + {5'b00000, body[12]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_tag_q <= '0;
    end else begin
      dec_tag_q <= tag_d;
    end
  end

  // Hold the fraction alongside the decoded tag.
  always_ff @(posedge clk_i) begin
    dec_frac_q <= body[11:0];
  end

  p16ln_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (dec_tag_q),
    .frac_i (dec_frac_q),
    .tag_o  (div_tag),
    .z_o    (div_z)
  );

  p16ln_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (div_tag),
    .z_i    (div_z),
    .tag_o  (poly_tag),
    .mant_o (poly_mant)
  );

  p16ln_enc u_enc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (poly_tag),
    .mant_i  (poly_mant),
    .valid_o (done_o),
    .posit_o (posit_out_o)
  );

endmodule

/* rtl/core/p16ln_chk.sv */
// Port-level checker for the posit16 natural log pipeline, bound to the top level.
// Depends on p16ln_pkg.
module p16ln_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [15:0] posit_in_i,
  input logic        done_o,
  input logic [15:0] posit_out_o
);
  import p16ln_pkg::*;

  // every strobe traces back to a request a fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching request");

  // every request gets its strobe
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("request lost in the pipeline");

  a_nar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(posit_in_i[15] || (posit_in_i == 16'h0000), LATENCY))
      |-> (posit_out_o == POSIT_NAR))
    else $error("NaR expected for zero or negative input");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(posit_in_i == 16'h4000, LATENCY)) |-> (posit_out_o == 16'h0000))
    else $error("log of one must be zero");

endmodule

bind posit16_natural_log_top p16ln_chk u_p16ln_chk (.*);
